[design/assert_macros.svh]
// Assertion macros used by the top level design file of the gated clock divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence on the same clock edge.
`define TGCD_ASSERT_NOW(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("tgcd assertion failed");

// Condition implies consequence on the following clock edge.
`define TGCD_ASSERT_NEXT(lbl, cond, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error("tgcd assertion failed");

`endif

[design/tgcd_pkg.sv]
// Package of the gated clock divider: widths, register indexes, types and helpers.
package tgcd_pkg;

   localparam int SampleBits  = 16;
   localparam int ThreshBits  = 16;
   localparam int CmpBits     = (SampleBits > ThreshBits) ? SampleBits : ThreshBits;
   localparam int SelBits     = 4;
   localparam int CountBits   = 7;
   localparam int CsrIdxBits  = 2;
   localparam int CsrDataBits = (ThreshBits > SelBits) ? ThreshBits : SelBits;

   typedef logic signed [SampleBits-1:0] sample_type;
   typedef logic signed [ThreshBits-1:0] thresh_type;
   typedef logic signed [CmpBits-1:0]    cmp_type;
   typedef logic [SelBits-1:0]           sel_type;
   typedef logic [CountBits-1:0]         count_type;
   typedef logic [CsrIdxBits-1:0]        csr_idx_type;
   typedef logic [CsrDataBits-1:0]       csr_data_type;

   // Register indexes
   localparam csr_idx_type CsrDivisorSelect = csr_idx_type'(0);
   localparam csr_idx_type CsrLowThreshold  = csr_idx_type'(1);
   localparam csr_idx_type CsrHighThreshold = csr_idx_type'(2);

   // Register reset values
   localparam sel_type    DivisorSelectReset = sel_type'(0);
   localparam thresh_type LowThresholdReset  = thresh_type'(100);
   localparam thresh_type HighThresholdReset = thresh_type'(2000);

   // Schmitt trigger result: new level and a rise flag
   typedef struct packed {
      logic level;
      logic fired;
   } trig_type;

   // Transport control handed to the divider for one word
   typedef struct packed {
      logic       clear;
      sample_type gated;
   } div_ctl_type;

   // Schmitt trigger: a high level tests the low threshold, a low level the high one
   function automatic trig_type schmitt(logic level, sample_type x,
                                        thresh_type lo, thresh_type hi);
      cmp_type  xe;
      cmp_type  le;
      cmp_type  he;
      trig_type r;
      xe = cmp_type'(x);
      le = cmp_type'(lo);
      he = cmp_type'(hi);
      r.level = level;
      r.fired = 1'b0;
      if (level) begin
         if (xe <= le) r.level = 1'b0;
      end else if (xe >= he) begin
         r.level = 1'b1;
         r.fired = 1'b1;
      end
      return r;
   endfunction

   // Division ratio table; selectors past the end saturate to the last entry
   function automatic count_type ratio(sel_type sel);
      count_type r;
      unique case (sel)
         4'd0:    r = count_type'(1);
         4'd1:    r = count_type'(3);
         4'd2:    r = count_type'(6);
         4'd3:    r = count_type'(12);
         4'd4:    r = count_type'(24);
         4'd5:    r = count_type'(48);
         4'd6:    r = count_type'(96);
         4'd7:    r = count_type'(2);
         4'd8:    r = count_type'(4);
         4'd9:    r = count_type'(8);
         4'd10:   r = count_type'(16);
         4'd11:   r = count_type'(32);
         default: r = count_type'(64);
      endcase
      return r;
   endfunction

endpackage

[design/tgcd_req_if.sv]
// Request channel of the gated clock divider: valid, ready and one sample word.
interface tgcd_req_if;
   logic                valid;
   logic                ready;
   tgcd_pkg::sample_type start_in;
   tgcd_pkg::sample_type continue_in;
   tgcd_pkg::sample_type stop_in;
   tgcd_pkg::sample_type clock_in;

   modport source (output valid, start_in, continue_in, stop_in, clock_in, input ready);
   modport sink   (input valid, start_in, continue_in, stop_in, clock_in, output ready);
endinterface

[design/tgcd_rsp_if.sv]
// Response channel of the gated clock divider: valid, ready and one result word.
interface tgcd_rsp_if;
   logic                valid;
   logic                ready;
   tgcd_pkg::sample_type reset_out;
   tgcd_pkg::sample_type clock_out;
   logic                running_flag;

   modport source (output valid, reset_out, clock_out, running_flag, input ready);
   modport sink   (input valid, reset_out, clock_out, running_flag, output ready);
endinterface

[design/tgcd_core.sv]
// Transport control: input triggers, running flag, reset release and clock gating.
module tgcd_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  tgcd_pkg::sample_type    start_in,
   input  tgcd_pkg::sample_type    continue_in,
   input  tgcd_pkg::sample_type    stop_in,
   input  tgcd_pkg::sample_type    clock_in,
   input  tgcd_pkg::thresh_type    low_threshold,
   input  tgcd_pkg::thresh_type    high_threshold,
   output tgcd_pkg::sample_type    reset_out,
   output logic                    running_flag,
   output tgcd_pkg::div_ctl_type   div_ctl
);

   logic start_level_ff, start_level_in;
   logic cont_level_ff,  cont_level_in;
   logic stop_level_ff,  stop_level_in;
   logic clk_level_ff,   clk_level_in;
   logic running_ff,     running_in;
   logic awaiting_ff,    awaiting_in;

   tgcd_pkg::trig_type st_trig;
   tgcd_pkg::trig_type ct_trig;
   tgcd_pkg::trig_type sp_trig;
   tgcd_pkg::trig_type ck_trig;
   logic               release_chk;

   // Trigger evaluation for the word in flight
   always_comb begin
      st_trig = tgcd_pkg::schmitt(start_level_ff, start_in, low_threshold, high_threshold);
      ct_trig = tgcd_pkg::schmitt(cont_level_ff, continue_in, low_threshold, high_threshold);
      sp_trig = tgcd_pkg::schmitt(stop_level_ff, stop_in, low_threshold, high_threshold);
      ck_trig = tgcd_pkg::schmitt(clk_level_ff, clock_in, low_threshold, high_threshold);

      start_level_in = st_trig.level;
      cont_level_in  = ct_trig.level;
      stop_level_in  = sp_trig.level;
      clk_level_in   = ck_trig.level;

      // Stop beats start or continue
      running_in = running_ff;
      if (st_trig.fired || ct_trig.fired) running_in = 1'b1;
      if (sp_trig.fired) running_in = 1'b0;

      // After start, hold reset until the clock trigger is high
      release_chk = st_trig.fired || awaiting_ff;
      awaiting_in = release_chk ? !ck_trig.level : awaiting_ff;
      reset_out   = (release_chk && ck_trig.level) ? clock_in : '0;

      running_flag  = running_in;
      div_ctl.clear = st_trig.fired;
      div_ctl.gated = (running_in && !awaiting_in) ? clock_in : '0;
   end

   // State update once per word
   always_ff @(posedge clock) begin
      if (reset) begin
         start_level_ff <= 1'b1;
         cont_level_ff  <= 1'b1;
         stop_level_ff  <= 1'b1;
         clk_level_ff   <= 1'b1;
         running_ff     <= 1'b0;
         awaiting_ff    <= 1'b0;
      end else if (step) begin
         start_level_ff <= start_level_in;
         cont_level_ff  <= cont_level_in;
         stop_level_ff  <= stop_level_in;
         clk_level_ff   <= clk_level_in;
         running_ff     <= running_in;
         awaiting_ff    <= awaiting_in;
      end
   end

endmodule

[design/tgcd_divider.sv]
// Divide counter: steps on falling edges of the gated clock, passes pulses at zero.
module tgcd_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tgcd_pkg::sel_type     divisor_select,
   input  tgcd_pkg::thresh_type  low_threshold,
   input  tgcd_pkg::thresh_type  high_threshold,
   input  tgcd_pkg::div_ctl_type div_ctl,
   output tgcd_pkg::sample_type  clock_out
);

   logic                gated_low_ff, gated_low_in;
   tgcd_pkg::count_type count_ff,     count_in;
   tgcd_pkg::count_type count_base;
   tgcd_pkg::count_type count_inc;
   tgcd_pkg::cmp_type   gated_ext;
   tgcd_pkg::cmp_type   lo_ext;
   tgcd_pkg::cmp_type   hi_ext;
   logic                fall;

   always_comb begin
      gated_ext = tgcd_pkg::cmp_type'(div_ctl.gated);
      lo_ext    = tgcd_pkg::cmp_type'(low_threshold);
      hi_ext    = tgcd_pkg::cmp_type'(high_threshold);

      // Inverted trigger: a fall to the low threshold is the event
      gated_low_in = gated_low_ff;
      fall         = 1'b0;
      if (gated_low_ff) begin
         if (gated_ext >= hi_ext) gated_low_in = 1'b0;
      end else if (gated_ext <= lo_ext) begin
         gated_low_in = 1'b1;
         fall         = 1'b1;
      end

      // Start clears first, then a fall steps modulo the ratio
      count_base = div_ctl.clear ? '0 : count_ff;
      count_inc  = tgcd_pkg::count_type'(count_base + 1'b1);
      if (fall) begin
         count_in = (count_inc >= tgcd_pkg::ratio(divisor_select)) ? '0 : count_inc;
      end else begin
         count_in = count_base;
      end

      clock_out = (count_in == '0) ? div_ctl.gated : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gated_low_ff <= 1'b1;
         count_ff     <= '0;
      end else if (step) begin
         gated_low_ff <= gated_low_in;
         count_ff     <= count_in;
      end
   end

endmodule

[design/transport_gated_clock_divider_top.sv]
// Top level of the gated clock divider: registers, input stage, result stage.
//
//  channel  | direction | word
//  ---------+-----------+----------------------------------------------------
//  req_ch   | in        | start_in, continue_in, stop_in, clock_in
//  rsp_ch   | out       | reset_out, clock_out, running_flag
//  csr_*    | in        | write enable, register index, write data
//
// One word enters per cycle unless the result register stalls; the result of a word
// passes the input register, then the trigger and counter logic, into the result register.
// Reset is synchronous and active high; it clears all control state and
// the registers to their default values.
// A stalled result holds the result register, and the input register keeps
// taking a new word whenever the result register empties in the same cycle.
`include "assert_macros.svh"

module transport_gated_clock_divider_top (
   input  logic                   clock,
   input  logic                   reset,
   tgcd_req_if.sink               req_ch,
   tgcd_rsp_if.source             rsp_ch,
   input  logic                   csr_we,
   input  tgcd_pkg::csr_idx_type  csr_index,
   input  tgcd_pkg::csr_data_type csr_wdata
);

   tgcd_pkg::sel_type    divisor_select_ff;
   tgcd_pkg::thresh_type low_threshold_ff;
   tgcd_pkg::thresh_type high_threshold_ff;

   logic                 in_valid_ff;
   tgcd_pkg::sample_type in_start_ff;
   tgcd_pkg::sample_type in_cont_ff;
   tgcd_pkg::sample_type in_stop_ff;
   tgcd_pkg::sample_type in_clk_ff;

   logic                 out_valid_ff;
   tgcd_pkg::sample_type out_reset_ff, out_reset_in;
   tgcd_pkg::sample_type out_clock_ff, out_clock_in;
   logic                 out_running_ff, out_running_in;

   tgcd_pkg::div_ctl_type div_ctl;
   logic                  advance;
   logic                  req_take;

   // Pipeline flow
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_select_ff <= tgcd_pkg::DivisorSelectReset;
         low_threshold_ff  <= tgcd_pkg::LowThresholdReset;
         high_threshold_ff <= tgcd_pkg::HighThresholdReset;
      end else if (csr_we) begin
         unique case (csr_index)
            tgcd_pkg::CsrDivisorSelect:
               divisor_select_ff <= csr_wdata[tgcd_pkg::SelBits-1:0];
            tgcd_pkg::CsrLowThreshold:
               low_threshold_ff  <= csr_wdata[tgcd_pkg::ThreshBits-1:0];
            tgcd_pkg::CsrHighThreshold:
               high_threshold_ff <= csr_wdata[tgcd_pkg::ThreshBits-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_start_ff <= req_ch.start_in;
         in_cont_ff  <= req_ch.continue_in;
         in_stop_ff  <= req_ch.stop_in;
         in_clk_ff   <= req_ch.clock_in;
      end
   end

   tgcd_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .start_in       (in_start_ff),
      .continue_in    (in_cont_ff),
      .stop_in        (in_stop_ff),
      .clock_in       (in_clk_ff),
      .low_threshold  (low_threshold_ff),
      .high_threshold (high_threshold_ff),
      .reset_out      (out_reset_in),
      .running_flag   (out_running_in),
      .div_ctl        (div_ctl)
   );

   tgcd_divider u_divider (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .divisor_select (divisor_select_ff),
      .low_threshold  (low_threshold_ff),
      .high_threshold (high_threshold_ff),
      .div_ctl        (div_ctl),
      .clock_out      (out_clock_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_reset_ff   <= out_reset_in;
         out_clock_ff   <= out_clock_in;
         out_running_ff <= out_running_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.reset_out    = out_reset_ff;
   assign rsp_ch.clock_out    = out_clock_ff;
   assign rsp_ch.running_flag = out_running_ff;

   // Checks
   `TGCD_ASSERT_NOW(a_stopped_no_clock, out_valid_ff && !out_running_ff, out_clock_ff == '0)
   `TGCD_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_ff)
   `TGCD_ASSERT_NEXT(a_stall_holds_in, in_valid_ff && !advance, in_valid_ff && $stable(in_clk_ff))

endmodule

[test/tb_top.sv]
// Self-checking testbench of the transport-gated clock divider: directed and random words.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit  = 2000;
   localparam int RatioCount = 13;

   typedef struct packed {
      tgcd_pkg::sample_type start_in;
      tgcd_pkg::sample_type continue_in;
      tgcd_pkg::sample_type stop_in;
      tgcd_pkg::sample_type clock_in;
   } sample_word_type;

   typedef struct packed {
      tgcd_pkg::sample_type reset_out;
      tgcd_pkg::sample_type clock_out;
      logic                 running_flag;
   } result_word_type;

   typedef enum int {IdleNone, IdleLight, IdleHeavy} idle_mode_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we;
   tgcd_pkg::csr_idx_type  csr_index;
   tgcd_pkg::csr_data_type csr_wdata;

   tgcd_req_if req_ch ();
   tgcd_rsp_if rsp_ch ();

   transport_gated_clock_divider_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Own copy of the transport state and registers
   tgcd_pkg::count_type  div_ratio [RatioCount] = '{7'd1, 7'd3, 7'd6, 7'd12, 7'd24, 7'd48,
                                                   7'd96, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32,
                                                   7'd64};
   tgcd_pkg::sel_type    mdl_sel;
   tgcd_pkg::thresh_type mdl_lo;
   tgcd_pkg::thresh_type mdl_hi;
   logic                 lvl_start, lvl_cont, lvl_stop, lvl_clk, lvl_gate;
   logic                 running, waiting;
   tgcd_pkg::count_type  div_count;

   sample_word_type pending_words [$];
   result_word_type expected_results [$];
   int unsigned     mismatches = 0;
   idle_mode_type   req_mode = IdleLight;
   idle_mode_type   rsp_mode = IdleLight;

   // Stimulus generator state
   logic clk_high = 1'b0;
   int   clk_left = 0;
   int   pulse_left [3] = '{0, 0, 0};

   // Schmitt trigger step: returns {new level, rose}
   function automatic logic [1:0] trigger(logic level, tgcd_pkg::sample_type x);
      if (level) return {(x > mdl_lo), 1'b0};
      if (x >= mdl_hi) return 2'b11;
      return 2'b00;
   endfunction

   // Advance the transport by one sample word and form its result word
   function automatic result_word_type advance_transport(sample_word_type w);
      logic [1:0]           t;
      logic                 rose_start;
      logic                 rose_cont;
      tgcd_pkg::sample_type gated;
      tgcd_pkg::count_type  lim;
      result_word_type      r;
      t = trigger(lvl_start, w.start_in);
      lvl_start  = t[1];
      rose_start = t[0];
      t = trigger(lvl_cont, w.continue_in);
      lvl_cont  = t[1];
      rose_cont = t[0];
      if (rose_start) div_count = '0;
      if (rose_start || rose_cont) running = 1'b1;
      // stop wins over start and continue in the same word
      t = trigger(lvl_stop, w.stop_in);
      lvl_stop = t[1];
      if (t[0]) running = 1'b0;
      t = trigger(lvl_clk, w.clock_in);
      lvl_clk = t[1];
      r.reset_out = '0;
      if (rose_start || waiting) begin
         if (lvl_clk) begin
            r.reset_out = w.clock_in;
            waiting     = 1'b0;
         end else begin
            waiting = 1'b1;
         end
      end
      gated = (running && !waiting) ? w.clock_in : '0;
      // falling edge of the gated clock steps the divider
      if (lvl_gate) begin
         if (gated >= mdl_hi) lvl_gate = 1'b0;
      end else if (gated <= mdl_lo) begin
         lvl_gate  = 1'b1;
         lim       = (mdl_sel >= RatioCount) ? div_ratio[RatioCount-1] : div_ratio[mdl_sel];
         div_count = div_count + 1'b1;
         if (div_count >= lim) div_count = '0;
      end
      r.clock_out    = (div_count == '0) ? gated : '0;
      r.running_flag = running;
      return r;
   endfunction

   function automatic tgcd_pkg::sample_type above(tgcd_pkg::thresh_type hi);
      int h;
      h = hi;
      return tgcd_pkg::sample_type'(h + int'($urandom_range(0, 32767 - h)));
   endfunction

   function automatic tgcd_pkg::sample_type below(tgcd_pkg::thresh_type lo);
      int l;
      l = lo;
      return tgcd_pkg::sample_type'(l - int'($urandom_range(0, l + 32768)));
   endfunction

   // Control line: mostly low, with short high pulses now and then
   function automatic tgcd_pkg::sample_type line_level(int idx, int unsigned odds);
      if (pulse_left[idx] == 0 && $urandom_range(0, odds) == 0)
         pulse_left[idx] = $urandom_range(1, 3);
      if (pulse_left[idx] != 0) begin
         pulse_left[idx]--;
         return above(mdl_hi);
      end
      return below(mdl_lo);
   endfunction

   // Mostly a square clock with sparse control pulses; some words are pure noise
   function automatic sample_word_type gen_word();
      sample_word_type w;
      if ($urandom_range(0, 9) == 0) begin
         w = {$urandom, $urandom};
         return w;
      end
      if (clk_left == 0) begin
         clk_high = !clk_high;
         clk_left = $urandom_range(1, 4);
      end
      clk_left--;
      w.clock_in    = clk_high ? above(mdl_hi) : below(mdl_lo);
      w.start_in    = line_level(0, 40);
      w.continue_in = line_level(1, 30);
      w.stop_in     = line_level(2, 30);
      return w;
   endfunction

   function automatic void queue_word(int s, int c, int p, int k);
      sample_word_type w;
      w.start_in    = tgcd_pkg::sample_type'(s);
      w.continue_in = tgcd_pkg::sample_type'(c);
      w.stop_in     = tgcd_pkg::sample_type'(p);
      w.clock_in    = tgcd_pkg::sample_type'(k);
      pending_words.push_back(w);
   endfunction

   function automatic int unsigned idle_cycles(idle_mode_type mode);
      case (mode)
         IdleNone:  return 0;
         IdleLight: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
         default:   return $urandom_range(0, 16);
      endcase
   endfunction

   // Request driver: one word at a time from the pending queue
   int unsigned     req_hold = 0;
   logic            word_held = 1'b0;
   sample_word_type cur_word;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_hold     <= 0;
         word_held = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(advance_transport(cur_word));
            word_held = 1'b0;
         end
         if (!word_held) begin
            if (req_hold != 0) begin
               req_hold     <= req_hold - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               cur_word  = pending_words.pop_front();
               word_held = 1'b1;
               req_ch.valid       <= 1'b1;
               req_ch.start_in    <= cur_word.start_in;
               req_ch.continue_in <= cur_word.continue_in;
               req_ch.stop_in     <= cur_word.stop_in;
               req_ch.clock_in    <= cur_word.clock_in;
               req_hold           <= idle_cycles(req_mode);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random back-pressure
   int unsigned     rsp_hold = 0;
   int unsigned     hold_next;
   result_word_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold     <= 0;
      end else begin
         hold_next = rsp_hold;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected word: reset_out %0d clock_out %0d running %0b",
                        $time, rsp_ch.reset_out, rsp_ch.clock_out, rsp_ch.running_flag);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.reset_out !== want.reset_out) begin
                  $display("%0t: reset_out expected %0d actual %0d",
                           $time, want.reset_out, rsp_ch.reset_out);
                  mismatches++;
               end
               if (rsp_ch.clock_out !== want.clock_out) begin
                  $display("%0t: clock_out expected %0d actual %0d",
                           $time, want.clock_out, rsp_ch.clock_out);
                  mismatches++;
               end
               if (rsp_ch.running_flag !== want.running_flag) begin
                  $display("%0t: running_flag expected %0b actual %0b",
                           $time, want.running_flag, rsp_ch.running_flag);
                  mismatches++;
               end
            end
            hold_next = idle_cycles(rsp_mode);
         end else if (hold_next != 0) begin
            hold_next--;
         end
         rsp_hold     <= hold_next;
         rsp_ch.ready <= (hold_next == 0);
      end
   end

   // Watchdog on cycles without any handshake or register write
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IdleLimit) begin
         $display("FAIL transport_gated_clock_divider_top");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(tgcd_pkg::csr_idx_type idx, tgcd_pkg::csr_data_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         tgcd_pkg::CsrDivisorSelect: mdl_sel = tgcd_pkg::sel_type'(val);
         tgcd_pkg::CsrLowThreshold:  mdl_lo = tgcd_pkg::thresh_type'(val);
         tgcd_pkg::CsrHighThreshold: mdl_hi = tgcd_pkg::thresh_type'(val);
         default: ;
      endcase
   endtask

   // Wait until every word is through and every result checked
   task automatic wait_drained();
      while (pending_words.size() != 0 || word_held || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int sel_v;
      int lo_v;
      int hi_v;
      int n;
      int a;
      int b;
      req_ch.valid       = 1'b0;
      req_ch.start_in    = '0;
      req_ch.continue_in = '0;
      req_ch.stop_in     = '0;
      req_ch.clock_in    = '0;
      rsp_ch.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = tgcd_pkg::CsrDivisorSelect;
      csr_wdata          = '0;
      mdl_sel   = tgcd_pkg::DivisorSelectReset;
      mdl_lo    = tgcd_pkg::LowThresholdReset;
      mdl_hi    = tgcd_pkg::HighThresholdReset;
      lvl_start = 1'b1;
      lvl_cont  = 1'b1;
      lvl_stop  = 1'b1;
      lvl_clk   = 1'b1;
      lvl_gate  = 1'b1;
      running   = 1'b0;
      waiting   = 1'b0;
      div_count = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset thresholds
      queue_word(0, 0, 0, 0);
      queue_word(-32768, -32768, -32768, -32768);
      queue_word(2000, 0, 0, 0);            // start at threshold, clock low: wait
      queue_word(0, 0, 0, 1999);
      queue_word(0, 0, 0, 32767);           // clock high releases the reset word
      queue_word(0, 0, 0, 100);
      queue_word(0, 0, 0, 101);
      queue_word(0, 0, 2000, 2000);         // stop
      queue_word(100, 100, 100, 100);
      queue_word(32767, 0, 32767, 32767);   // start and stop together, clock high
      queue_word(0, 0, 0, 0);
      queue_word(32767, 0, 32767, 0);       // start and stop together, clock low
      queue_word(0, 32767, 0, 0);           // continue while waiting
      queue_word(0, 0, 0, 32767);
      queue_word(0, 0, 0, -32768);
      queue_word(0, 0, 0, 32767);
      queue_word(1999, 1999, 1999, -1);
      queue_word(21845, -21846, 21845, -21846);
      queue_word(-21846, 21845, -21846, 21845);
      queue_word(-1, -1, -1, -1);
      queue_word(32767, 32767, 0, 32767);
      queue_word(0, 0, 0, 101);
      queue_word(0, 0, 0, -32768);
      wait_drained();

      // Random phases, each under its own register setting
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin sel_v = 6;  lo_v = 100;    hi_v = 2000;  n = 450; end
            1: begin sel_v = 0;  lo_v = -32768; hi_v = 32767; n = 120; end  // wraps a high count
            2: begin sel_v = 15; lo_v = 500;    hi_v = 1000;  n = 120; end
            3: begin sel_v = 1;  lo_v = 3000;   hi_v = -3000; n = 120; end  // inverted thresholds
            default: begin
               sel_v = $urandom_range(0, 15);
               a = int'($urandom_range(0, 65535)) - 32768;
               b = int'($urandom_range(0, 65535)) - 32768;
               lo_v = (a < b) ? a : b;
               hi_v = (a < b) ? b : a;
               if ($urandom_range(0, 3) == 0) begin
                  lo_v = hi_v;
                  hi_v = (a < b) ? a : b;
               end
               n = 110;
            end
         endcase
         write_reg(tgcd_pkg::CsrDivisorSelect, tgcd_pkg::csr_data_type'(sel_v));
         write_reg(tgcd_pkg::CsrLowThreshold, tgcd_pkg::csr_data_type'(lo_v));
         write_reg(tgcd_pkg::CsrHighThreshold, tgcd_pkg::csr_data_type'(hi_v));
         @(posedge clock);
         csr_we <= 1'b0;
         req_mode = idle_mode_type'($urandom_range(0, 2));
         rsp_mode = idle_mode_type'($urandom_range(0, 2));
         for (int i = 0; i < n; i++)
            pending_words.push_back(gen_word());
         wait_drained();
      end

      if (mismatches == 0)
         $display("PASS transport_gated_clock_divider_top");
      else
         $display("FAIL transport_gated_clock_divider_top");
      $finish;
   end

endmodule
